/* sv/sws_pkg.sv */
package sws_pkg;

  localparam int unsigned COORD_BITS_DEF   = 24;
  localparam int unsigned MAX_SEGMENTS_DEF = 32;
  localparam int unsigned TENSION_BITS     = 16;
  localparam int unsigned SEG_FIELD_BITS   = 6;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned ROUND_HALF       = 32768;

  // Occupancy flags of the span queue, seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

/* sv/sws_if.sv */
interface sws_pt_if #(
  parameter int unsigned COORD_BITS = sws_pkg::COORD_BITS_DEF
);
  import sws_pkg::*;
  logic                             valid;
  logic                             ready;
  logic signed [COORD_BITS-1:0]     point_x;
  logic signed [COORD_BITS-1:0]     point_y;
  logic signed [COORD_BITS-1:0]     point_z;
  logic        [TENSION_BITS-1:0]   tension_q16;
  logic        [SEG_FIELD_BITS-1:0] segment_count;
  logic                             last_point;

  modport source (output valid, point_x, point_y, point_z, tension_q16, segment_count,
                  last_point, input ready);
  modport sink (input valid, point_x, point_y, point_z, tension_q16, segment_count,
                last_point, output ready);
endinterface

interface sws_smp_if #(
  parameter int unsigned COORD_BITS = sws_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] sample_x;
  logic signed [COORD_BITS-1:0] sample_y;
  logic signed [COORD_BITS-1:0] sample_z;
  logic                         run_end;

  modport source (output valid, sample_x, sample_y, sample_z, run_end, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, run_end, output ready);
endinterface

/* sv/spline_waypoint_bezier_sampler.sv */
// Channel   Modport        Moves
// pt_i      sink           one waypoint per transfer
// smp_o     source         one curve sample per transfer
//
// The front takes a waypoint and runs it through its difference, multiply and
// span states to work out the control points and queue up to two spans. The
// back works out each sample in its weight, accumulate, divide and output
// states, with a bit-per-cycle quotient loop that divides by N cubed. Reset
// clears the curve history. Either side stalls alone: the two-entry span queue
// and the output register keep the front and back apart.
module spline_waypoint_bezier_sampler #(
  parameter int unsigned MAX_SEGMENTS = sws_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_BITS   = sws_pkg::COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sws_pt_if.sink     pt_i,
  sws_smp_if.source  smp_o
);
  import sws_pkg::*;

  localparam int unsigned NW     = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SPAN_W = 12 * COORD_BITS + NW + 1;

  logic              push;
  logic              pop;
  logic [SPAN_W-1:0] span_in;
  logic [SPAN_W-1:0] span_out;
  q_status_t         q_stat;

  sws_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pt_i     (pt_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .span_o   (span_in)
  );

  sws_queue #(
    .SPAN_W (SPAN_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (span_in),
    .pop_i  (pop),
    .data_o (span_out),
    .stat_o (q_stat)
  );

  sws_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .span_i   (span_out),
    .pop_o    (pop),
    .smp_o    (smp_o)
  );

endmodule

/* sv/sws_front.sv */
module sws_front #(
  parameter int unsigned MAX_SEGMENTS = sws_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_BITS   = sws_pkg::COORD_BITS_DEF,
  localparam int unsigned NW     = $clog2(MAX_SEGMENTS + 1),
  localparam int unsigned SPAN_W = 12 * COORD_BITS + NW + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sws_pt_if.sink              pt_i,
  input  sws_pkg::q_status_t  q_stat_i,
  output logic                push_o,
  output logic [SPAN_W-1:0]   span_o
);
  import sws_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned TB = TENSION_BITS;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_DIF   = 3'd1;
  localparam logic [2:0] F_MUL   = 3'd2;
  localparam logic [2:0] F_SPAN1 = 3'd3;
  localparam logic [2:0] F_SPAN2 = 3'd4;

  logic [2:0] st_q, st_d;
  logic [1:0] ps_q, ps_d;

  logic signed [CB-1:0] older_q [3];
  logic signed [CB-1:0] newer_q [3];
  logic signed [CB-1:0] pend_q  [3];
  logic signed [CB-1:0] pend_d  [3];
  logic [TB-1:0]        ot_q, nt_q;
  logic [NW-1:0]        os_q, ns_q;

  logic signed [CB-1:0] p_q [3];
  logic [TB-1:0]        t_q;
  logic [NW-1:0]        s_q;
  logic                 last_q;

  logic signed [CB:0]   da_q [3];
  logic signed [CB:0]   db_q [3];
  logic signed [CB+1:0] sa_q [3];
  logic signed [CB+1:0] sb_q [3];

  logic signed [CB+17:0] prod_a [3];
  logic signed [CB+17:0] prod_b [3];
  logic signed [CB-1:0]  near_c [3];
  logic signed [CB-1:0]  far_in [3];
  logic signed [CB-1:0]  far_fn [3];
  logic [NW-1:0]         seg_c;
  logic                  finish;
  logic signed [CB-1:0]  pin [3];

  function automatic logic signed [CB-1:0] sat_c(input logic signed [CB+2:0] v);
    logic signed [CB+2:0] hi;
    logic signed [CB+2:0] lo;
    hi = $signed({4'b0000, {(CB-1){1'b1}}});
    lo = $signed({4'b1111, {(CB-1){1'b0}}});
    if (v > hi) begin
      sat_c = hi[CB-1:0];
    end else if (v < lo) begin
      sat_c = lo[CB-1:0];
    end else begin
      sat_c = v[CB-1:0];
    end
  endfunction

  function automatic logic signed [CB+2:0] ext3(input logic signed [CB-1:0] v);
    ext3 = $signed({{3{v[CB-1]}}, v});
  endfunction

  function automatic logic signed [CB+2:0] ext_s(input logic signed [CB+1:0] v);
    ext_s = $signed({v[CB+1], v});
  endfunction

  assign pin[0] = pt_i.point_x;
  assign pin[1] = pt_i.point_y;
  assign pin[2] = pt_i.point_z;

  assign pt_i.ready = (st_q == F_IDLE);

  always_comb begin
    if (pt_i.segment_count == '0) begin
      seg_c = NW'(1);
    end else if (int'(pt_i.segment_count) > int'(MAX_SEGMENTS)) begin
      seg_c = NW'(MAX_SEGMENTS);
    end else begin
      seg_c = NW'(pt_i.segment_count);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_a[j] = (CB+18)'(da_q[j]) *
                  (CB+18)'($signed({1'b0, ((ps_q == 2'd2) ? ot_q : nt_q)}));
      prod_b[j] = (CB+18)'(db_q[j]) * (CB+18)'($signed({1'b0, nt_q}));
      near_c[j] = sat_c(ext3(newer_q[j]) + ext_s(sa_q[j]));
      far_in[j] = sat_c(ext3(newer_q[j]) - ext_s(sa_q[j]));
      far_fn[j] = sat_c(ext3(p_q[j]) + ext_s(sb_q[j]));
    end
  end

  // Span word: flag, count, then P3, C2, C1, P0 with x in the low bits of each.
  always_comb begin
    st_d   = st_q;
    ps_d   = ps_q;
    push_o = 1'b0;
    finish = 1'b0;
    span_o = '0;
    for (int j = 0; j < 3; j++) begin
      pend_d[j] = pend_q[j];
    end
    case (st_q)
      F_IDLE: begin
        if (pt_i.valid) begin
          st_d = F_DIF;
        end
      end
      F_DIF: begin
        st_d = F_MUL;
      end
      F_MUL: begin
        st_d = F_SPAN1;
      end
      F_SPAN1: begin
        if (ps_q == 2'd2) begin
          for (int j = 0; j < 3; j++) begin
            span_o[j*CB +: CB]       = older_q[j];
            span_o[(3+j)*CB +: CB]   = pend_q[j];
            span_o[(6+j)*CB +: CB]   = far_in[j];
            span_o[(9+j)*CB +: CB]   = newer_q[j];
          end
          span_o[12*CB +: NW] = os_q;
          span_o[12*CB+NW]    = ~last_q;
        end
        if (ps_q != 2'd0 && !(ps_q == 2'd2 && q_stat_i.full)) begin
          push_o = (ps_q == 2'd2);
          for (int j = 0; j < 3; j++) begin
            pend_d[j] = near_c[j];
          end
          if (last_q) begin
            st_d = F_SPAN2;
          end else begin
            finish = 1'b1;
          end
        end else if (ps_q == 2'd0) begin
          finish = 1'b1;
        end
      end
      F_SPAN2: begin
        for (int j = 0; j < 3; j++) begin
          span_o[j*CB +: CB]     = newer_q[j];
          span_o[(3+j)*CB +: CB] = pend_q[j];
          span_o[(6+j)*CB +: CB] = far_fn[j];
          span_o[(9+j)*CB +: CB] = p_q[j];
        end
        span_o[12*CB +: NW] = ns_q;
        span_o[12*CB+NW]    = 1'b1;
        if (!q_stat_i.full) begin
          push_o = 1'b1;
          finish = 1'b1;
        end
      end
      default: begin
        st_d = F_IDLE;
      end
    endcase
    if (finish) begin
      st_d = F_IDLE;
      if (last_q) begin
        ps_d = 2'd0;
      end else if (ps_q != 2'd2) begin
        ps_d = ps_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
      ps_q <= 2'd0;
      ot_q <= '0;
      nt_q <= '0;
      os_q <= NW'(1);
      ns_q <= NW'(1);
      for (int j = 0; j < 3; j++) begin
        older_q[j] <= '0;
        newer_q[j] <= '0;
        pend_q[j]  <= '0;
      end
    end else begin
      st_q <= st_d;
      ps_q <= ps_d;
      for (int j = 0; j < 3; j++) begin
        pend_q[j] <= pend_d[j];
      end
      if (finish) begin
        for (int j = 0; j < 3; j++) begin
          older_q[j] <= newer_q[j];
          newer_q[j] <= p_q[j];
        end
        ot_q <= nt_q;
        nt_q <= t_q;
        os_q <= ns_q;
        ns_q <= s_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == F_IDLE && pt_i.valid) begin
      for (int j = 0; j < 3; j++) begin
        p_q[j] <= pin[j];
      end
      t_q    <= pt_i.tension_q16;
      s_q    <= seg_c;
      last_q <= pt_i.last_point;
    end
    if (st_q == F_DIF) begin
      for (int j = 0; j < 3; j++) begin
        if (ps_q == 2'd2) begin
          da_q[j] <= $signed({p_q[j][CB-1], p_q[j]}) - $signed({older_q[j][CB-1], older_q[j]});
        end else begin
          da_q[j] <= $signed({p_q[j][CB-1], p_q[j]}) - $signed({newer_q[j][CB-1], newer_q[j]});
        end
        db_q[j] <= $signed({newer_q[j][CB-1], newer_q[j]}) - $signed({p_q[j][CB-1], p_q[j]});
      end
    end
    if (st_q == F_MUL) begin
      // Round half up, then an arithmetic shift gives the floor.
      for (int j = 0; j < 3; j++) begin
        sa_q[j] <=
          (CB+2)'((prod_a[j] + $signed((CB+18)'(ROUND_HALF))) >>> TB);
        sb_q[j] <=
          (CB+2)'((prod_b[j] + $signed((CB+18)'(ROUND_HALF))) >>> TB);
      end
    end
  end

endmodule

/* sv/sws_queue.sv */
module sws_queue #(
  parameter int unsigned SPAN_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [SPAN_W-1:0]  data_i,
  input  logic               pop_i,
  output logic [SPAN_W-1:0]  data_o,
  output sws_pkg::q_status_t stat_o
);
  import sws_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [SPAN_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [CW-1:0]     cnt_q;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(QUEUE_DEPTH));
  assign data_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* sv/sws_back.sv */
module sws_back #(
  parameter int unsigned MAX_SEGMENTS = sws_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_BITS   = sws_pkg::COORD_BITS_DEF,
  localparam int unsigned NW     = $clog2(MAX_SEGMENTS + 1),
  localparam int unsigned SPAN_W = 12 * COORD_BITS + NW + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sws_pkg::q_status_t q_stat_i,
  input  logic [SPAN_W-1:0]  span_i,
  output logic               pop_o,
  sws_smp_if.source          smp_o
);
  import sws_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned WB  = 3 * NW;
  localparam int unsigned AW  = CB + WB + 2;
  localparam int unsigned QB  = CB + 1;
  localparam int unsigned KW  = $clog2(QB);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_W1   = 3'd1;
  localparam logic [2:0] B_W2   = 3'd2;
  localparam logic [2:0] B_ACC  = 3'd3;
  localparam logic [2:0] B_DSET = 3'd4;
  localparam logic [2:0] B_DIV  = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0]      st_q;
  logic [NW-1:0]   i_q, a_q, b_q;
  logic [2*NW-1:0] a2_q, b2_q, ab_q, nn_q;
  logic [WB-1:0]   w_q [4];
  logic [WB-1:0]   den_q;
  logic [1:0]      k_q;
  logic [KW-1:0]   cnt_q;

  logic signed [AW-1:0] acc_q [3];
  logic [WB:0]          rem_q [3];
  logic [QB-1:0]        dvd_q [3];
  logic [QB-1:0]        quo_q [3];
  logic                 neg_q [3];

  logic                 ov_q;
  logic signed [CB-1:0] res_q [3];
  logic                 re_q;

  logic [NW-1:0]        n_c;
  logic                 flag_c;
  logic signed [CB-1:0] coef_c [3];
  logic signed [CB+WB:0] prod_c [3];
  logic [WB:0]          vv_c;
  logic signed [AW-1:0] dd_c [3];
  logic [AW-1:0]        mm_c [3];
  logic [WB+1:0]        trial_c [3];
  logic signed [QB:0]   sq_c [3];
  logic signed [CB-1:0] sat_c [3];
  logic                 last_c;
  logic                 slot_free;
  logic [3*NW+1:0]      w1_c, w2_c;
  logic [3*NW-1:0]      p1_c, p2_c;

  assign n_c    = span_i[12*CB +: NW];
  assign flag_c = span_i[12*CB+NW];
  assign vv_c   = {den_q, 1'b0};
  assign last_c = (NW'(i_q + 1'b1) == n_c);
  assign slot_free = !ov_q || smp_o.ready;

  assign p1_c = {{NW{1'b0}}, ab_q} * {{(2*NW){1'b0}}, a_q};
  assign p2_c = {{NW{1'b0}}, ab_q} * {{(2*NW){1'b0}}, b_q};
  assign w1_c = {2'b00, p1_c} + {1'b0, p1_c, 1'b0};
  assign w2_c = {2'b00, p2_c} + {1'b0, p2_c, 1'b0};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coef_c[j] = span_i[(int'(k_q) * 3 + j) * CB +: CB];
      prod_c[j] = (CB+WB+1)'(coef_c[j]) * (CB+WB+1)'($signed({1'b0, w_q[k_q]}));
      dd_c[j]   = (acc_q[j] <<< 1) + $signed({{(AW-WB){1'b0}}, den_q});
      if (dd_c[j] < 0) begin
        mm_c[j] = AW'(-dd_c[j] + $signed({{(AW-WB-1){1'b0}}, vv_c}) - $signed(AW'(1)));
      end else begin
        mm_c[j] = dd_c[j];
      end
      trial_c[j] = {rem_q[j], dvd_q[j][QB-1]};
      sq_c[j] = neg_q[j] ? -$signed({1'b0, quo_q[j]}) : $signed({1'b0, quo_q[j]});
      if (sq_c[j] > $signed({3'b000, {(CB-1){1'b1}}})) begin
        sat_c[j] = {1'b0, {(CB-1){1'b1}}};
      end else if (sq_c[j] < $signed({3'b111, {(CB-1){1'b0}}})) begin
        sat_c[j] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        sat_c[j] = sq_c[j][CB-1:0];
      end
    end
  end

  assign pop_o = (st_q == B_OUT) && slot_free && last_c;

  assign smp_o.valid    = ov_q;
  assign smp_o.sample_x = res_q[0];
  assign smp_o.sample_y = res_q[1];
  assign smp_o.sample_z = res_q[2];
  assign smp_o.run_end  = re_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= B_IDLE;
      i_q   <= '0;
      k_q   <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (st_q == B_OUT && slot_free) begin
        ov_q <= 1'b1;
      end else if (smp_o.ready) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        B_IDLE: begin
          if (!q_stat_i.empty) begin
            st_q <= B_W1;
          end
        end
        B_W1: begin
          st_q <= B_W2;
        end
        B_W2: begin
          k_q  <= '0;
          st_q <= B_ACC;
        end
        B_ACC: begin
          k_q <= k_q + 1'b1;
          if (k_q == 2'd3) begin
            st_q <= B_DSET;
          end
        end
        B_DSET: begin
          cnt_q <= '0;
          st_q  <= B_DIV;
        end
        B_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == KW'(QB - 1)) begin
            st_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (slot_free) begin
            if (last_c) begin
              i_q  <= '0;
              st_q <= B_IDLE;
            end else begin
              i_q  <= i_q + 1'b1;
              st_q <= B_W1;
            end
          end
        end
        default: begin
          st_q <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      B_W1: begin
        a_q  <= n_c - i_q;
        b_q  <= i_q;
        a2_q <= {{NW{1'b0}}, n_c - i_q} * {{NW{1'b0}}, n_c - i_q};
        b2_q <= {{NW{1'b0}}, i_q} * {{NW{1'b0}}, i_q};
        ab_q <= {{NW{1'b0}}, n_c - i_q} * {{NW{1'b0}}, i_q};
        nn_q <= {{NW{1'b0}}, n_c} * {{NW{1'b0}}, n_c};
      end
      B_W2: begin
        w_q[0] <= WB'(a2_q * a_q);
        w_q[1] <= WB'(w1_c);
        w_q[2] <= WB'(w2_c);
        w_q[3] <= WB'(b2_q * b_q);
        den_q  <= WB'(nn_q * n_c);
        for (int j = 0; j < 3; j++) begin
          acc_q[j] <= '0;
        end
      end
      B_ACC: begin
        for (int j = 0; j < 3; j++) begin
          acc_q[j] <= acc_q[j] + AW'(prod_c[j]);
        end
      end
      B_DSET: begin
        // Floor of a negative quotient: divide the magnitude rounded up.
        for (int j = 0; j < 3; j++) begin
          neg_q[j] <= dd_c[j][AW-1];
          rem_q[j] <= mm_c[j][AW-1:QB];
          dvd_q[j] <= mm_c[j][QB-1:0];
          quo_q[j] <= '0;
        end
      end
      B_DIV: begin
        for (int j = 0; j < 3; j++) begin
          dvd_q[j] <= {dvd_q[j][QB-2:0], 1'b0};
          if (trial_c[j] >= {1'b0, vv_c}) begin
            rem_q[j] <= (WB+1)'(trial_c[j] - {1'b0, vv_c});
            quo_q[j] <= {quo_q[j][QB-2:0], 1'b1};
          end else begin
            rem_q[j] <= trial_c[j][WB:0];
            quo_q[j] <= {quo_q[j][QB-2:0], 1'b0};
          end
        end
      end
      B_OUT: begin
        if (slot_free) begin
          for (int j = 0; j < 3; j++) begin
            res_q[j] <= sat_c[j];
          end
          re_q <= flag_c && last_c;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/sv/tb_spline_waypoint_bezier_sampler.sv */
`timescale 1ns / 1ps

module tb_spline_waypoint_bezier_sampler;
  import sws_pkg::*;

  localparam int CB         = COORD_BITS_DEF;
  localparam int MAX_SEG    = MAX_SEGMENTS_DEF;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    logic signed [CB-1:0]             x;
    logic signed [CB-1:0]             y;
    logic signed [CB-1:0]             z;
    logic        [TENSION_BITS-1:0]   tension;
    logic        [SEG_FIELD_BITS-1:0] segs;
    logic                             is_last;
    bit                               hold;
  } waypoint_t;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 run_end;
  } sample_t;

  logic clk_i;
  logic rst_ni;

  sws_pt_if  pt ();
  sws_smp_if smp ();

  spline_waypoint_bezier_sampler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt),
    .smp_o  (smp)
  );

  waypoint_t waypoint_q[$];
  sample_t   sample_q[$];
  int        errors;
  int        idle_cycles;
  int        send_gap;
  int        recv_gap;

  // Curve history of the predictor.
  longint    hist_old[3];
  longint    hist_new[3];
  longint    left_ctrl[3];
  int        tens_old;
  int        tens_new;
  int        segs_old;
  int        segs_new;
  int        held_points;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint saturate(longint v);
    longint hi;
    hi = (longint'(1) <<< (CB - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint apply_tension(longint d, int t);
    return floor_div(d * t + ROUND_HALF, 65536);
  endfunction

  task automatic emit_span(longint p0[3], longint c1[3], longint c2[3], longint p3[3],
                           int n);
    longint  den, a, b, num;
    sample_t s;
    longint  v[3];
    den = longint'(n) * n * n;
    for (int i = 0; i < n; i++) begin
      b = i;
      a = n - i;
      for (int j = 0; j < 3; j++) begin
        num = p0[j] * a * a * a + c1[j] * 3 * b * a * a + c2[j] * 3 * b * b * a
              + p3[j] * b * b * b;
        v[j] = saturate(floor_div(2 * num + den, 2 * den));
      end
      s.x = v[0][CB-1:0];
      s.y = v[1][CB-1:0];
      s.z = v[2][CB-1:0];
      s.run_end = 1'b0;
      sample_q.insert(sample_q.size(), s);
    end
  endtask

  task automatic predict_samples(waypoint_t w);
    longint p[3];
    longint far_ctrl[3];
    longint next_left[3];
    longint diff;
    int     seg;
    int     prior_count;
    prior_count = sample_q.size();
    p[0] = w.x;
    p[1] = w.y;
    p[2] = w.z;
    seg = (w.segs == 0) ? 1 : ((w.segs > MAX_SEG) ? MAX_SEG : int'(w.segs));
    if (held_points >= 2) begin
      for (int j = 0; j < 3; j++) begin
        diff = apply_tension(p[j] - hist_old[j], tens_old);
        far_ctrl[j] = saturate(hist_new[j] - diff);
        next_left[j] = saturate(hist_new[j] + diff);
      end
      emit_span(hist_old, left_ctrl, far_ctrl, hist_new, segs_old);
      left_ctrl = next_left;
    end else if (held_points == 1) begin
      for (int j = 0; j < 3; j++)
        left_ctrl[j] = saturate(hist_new[j] + apply_tension(p[j] - hist_new[j], tens_new));
    end
    if (w.is_last && held_points >= 1) begin
      for (int j = 0; j < 3; j++)
        far_ctrl[j] = saturate(p[j] + apply_tension(hist_new[j] - p[j], tens_new));
      emit_span(hist_new, left_ctrl, far_ctrl, p, segs_new);
    end
    hist_old = hist_new;
    hist_new = p;
    tens_old = tens_new;
    tens_new = w.tension;
    segs_old = segs_new;
    segs_new = seg;
    if (w.is_last) held_points = 0;
    else if (held_points < 2) held_points++;
    if (sample_q.size() > prior_count) sample_q[sample_q.size() - 1].run_end = 1'b1;
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return CB'($signed($urandom_range(0, 8191)) - 4096);
    if (r < 9) return CB'($urandom);
    return (r[0]) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
  endfunction

  task automatic add_point(int x, int y, int z, int t, int s, bit lst, bit hold);
    waypoint_t w;
    w.x = x[CB-1:0];
    w.y = y[CB-1:0];
    w.z = z[CB-1:0];
    w.tension = t[TENSION_BITS-1:0];
    w.segs = s[SEG_FIELD_BITS-1:0];
    w.is_last = lst;
    w.hold = hold;
    waypoint_q.insert(waypoint_q.size(), w);
  endtask

  task automatic add_random_curve(bit hold);
    int len;
    int r;
    int s;
    len = $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 19);
      if (r < 15) s = $urandom_range(1, 6);
      else if (r < 18) s = $urandom_range(0, 63);
      else s = MAX_SEG;
      // A few waypoints break a curve off early or carry no end mark.
      add_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 65535), s,
                (k == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0),
                hold && k == 0);
    end
  endtask

  // Driver: a waypoint is predicted when it is placed on the channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt.valid         <= 1'b0;
      pt.point_x       <= '0;
      pt.point_y       <= '0;
      pt.point_z       <= '0;
      pt.tension_q16   <= '0;
      pt.segment_count <= '0;
      pt.last_point    <= 1'b0;
      send_gap         <= 0;
    end else if (!pt.valid || pt.ready) begin
      if (send_gap > 0) begin
        pt.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (waypoint_q.size() > 0 && !(waypoint_q[0].hold && sample_q.size() > 0)) begin
        waypoint_t w;
        w = waypoint_q.pop_front();
        predict_samples(w);
        pt.valid         <= 1'b1;
        pt.point_x       <= w.x;
        pt.point_y       <= w.y;
        pt.point_z       <= w.z;
        pt.tension_q16   <= w.tension;
        pt.segment_count <= w.segs;
        pt.last_point    <= w.is_last;
        send_gap         <= pick_gap();
      end else begin
        pt.valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp.ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (smp.valid && smp.ready) begin
        if (sample_q.size() == 0) begin
          $display("%0t: unexpected sample x=%0d y=%0d z=%0d end=%0b", $realtime,
                   smp.sample_x, smp.sample_y, smp.sample_z, smp.run_end);
          errors++;
        end else begin
          sample_t e;
          e = sample_q.pop_front();
          if (e.x !== smp.sample_x || e.y !== smp.sample_y || e.z !== smp.sample_z ||
              e.run_end !== smp.run_end) begin
            $display("%0t: sample mismatch expected x=%0d y=%0d z=%0d end=%0b",
                     $realtime, e.x, e.y, e.z, e.run_end);
            $display("%0t:                 actual   x=%0d y=%0d z=%0d end=%0b",
                     $realtime, smp.sample_x, smp.sample_y, smp.sample_z, smp.run_end);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        smp.ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else begin
        smp.ready <= 1'b1;
        recv_gap  <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pt.valid && pt.ready) || (smp.valid && smp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    errors      = 0;
    idle_cycles = 0;
    hist_old    = '{0, 0, 0};
    hist_new    = '{0, 0, 0};
    left_ctrl   = '{0, 0, 0};
    tens_old    = 0;
    tens_new    = 0;
    segs_old    = 1;
    segs_new    = 1;
    held_points = 0;
    // One-point curve, then a two-point curve with both end rules.
    add_point(100, -200, 300, 1000, 4, 1'b1, 1'b0);
    add_point(0, 0, 0, 65535, 3, 1'b0, 1'b0);
    add_point(2560, -2560, 1280, 0, 2, 1'b1, 1'b0);
    // Extremes of position and tension, segment counts zero, full and above range.
    add_point(CMIN, CMAX, CMIN, 65535, 0, 1'b0, 1'b0);
    add_point(CMAX, CMIN, CMAX, 65535, 63, 1'b0, 1'b0);
    add_point(CMIN, CMIN, CMAX, 0, MAX_SEG, 1'b0, 1'b0);
    add_point(CMAX, CMAX, CMIN, 32768, 1, 1'b0, 1'b0);
    add_point(-1, 1, 0, 12345, 33, 1'b1, 1'b1);
    // Long curve with small hand-picked content.
    add_point(10, 20, 30, 16384, 5, 1'b0, 1'b0);
    add_point(-400, 800, 50, 49152, 2, 1'b0, 1'b0);
    add_point(700, -30, -900, 8192, 3, 1'b0, 1'b0);
    add_point(0, 0, 0, 65535, 1, 1'b0, 1'b0);
    add_point(5000, 5000, -5000, 30000, 6, 1'b1, 1'b0);
    while (waypoint_q.size() < 180) add_random_curve(waypoint_q.size() > 90 &&
                                                     waypoint_q.size() < 97);
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (waypoint_q.size() == 0 && !pt.valid && sample_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && sample_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* spline_waypoint_bezier_sampler.f */
sv/sws_pkg.sv
sv/sws_if.sv
sv/sws_front.sv
sv/sws_queue.sv
sv/sws_back.sv
sv/spline_waypoint_bezier_sampler.sv
tb/sv/tb_spline_waypoint_bezier_sampler.sv
